// ----- design/ajb_pkg.sv -----
`timescale 1ns / 1ps

package ajb_pkg;

    localparam int BUFFER_DEPTH = 16384;
    localparam int SAMPLE_BITS  = 24;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = PTR_W + 1;
    localparam int FRAME_W      = 12;
    localparam int THR_W        = 15;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 15;
    localparam int Q_DEPTH      = 2;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int Q_CW         = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FILL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FILL     = 2'd2;

    localparam logic [FRAME_W-1:0] FRAME_LENGTH_RST = 12'd960;
    localparam logic [THR_W-1:0]   TARGET_FILL_RST  = 15'd2880;
    localparam logic [THR_W-1:0]   MAX_FILL_RST     = 15'd9600;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    typedef struct packed {
        t_op                           op;
        logic                          first;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ----- design/ajb_if.sv -----
`timescale 1ns / 1ps

interface ajb_in_if import ajb_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          first;

    modport source (output valid, kind, sample_in, first, input ready);
    modport sink   (input valid, kind, sample_in, first, output ready);
endinterface

interface ajb_out_if import ajb_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          out_valid;
    logic [FILL_W-1:0]             fill_level;
    logic                          is_primed;
    logic [CNT_W-1:0]              underrun_total;
    logic [CNT_W-1:0]              drop_total;
    logic                          overflow;

    modport source (output valid, sample_out, out_valid, fill_level, is_primed,
                    underrun_total, drop_total, overflow, input ready);
    modport sink   (input valid, sample_out, out_valid, fill_level, is_primed,
                    underrun_total, drop_total, overflow, output ready);
endinterface

// ----- design/ajb_front.sv -----
`timescale 1ns / 1ps

module ajb_front import ajb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ajb_in_if.sink   i_in,
    output logic     o_q_valid,
    output t_item    o_q_item,
    input  logic     i_q_pop
);

    t_item             r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_CW-1:0]   r_cnt;
    logic [Q_CW-1:0]   n_cnt;
    logic              push;
    logic              pop;
    t_item             item;

    assign i_in.ready = (r_cnt < Q_CW'(Q_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_q_pop && (r_cnt != '0);

    always_comb begin
        item.op     = t_op'(i_in.kind);
        item.first  = i_in.first;
        item.sample = i_in.sample_in;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= item;
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd];

endmodule

// ----- design/ajb_back.sv -----
`timescale 1ns / 1ps

module ajb_back import ajb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_wr  i_cfg,
    input  logic     i_q_valid,
    input  t_item    i_q_item,
    output logic     o_q_pop,
    ajb_out_if.source o_res
);

    logic signed [SAMPLE_BITS-1:0] r_store [BUFFER_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;

    logic [FRAME_W-1:0] r_frame;
    logic [THR_W-1:0]   r_target;
    logic [THR_W-1:0]   r_max;

    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_primed, n_primed;
    logic               r_silent, n_silent;
    logic               r_underran, n_underran;
    logic [CNT_W-1:0]   r_under_cnt, n_under_cnt;
    logic [CNT_W-1:0]   r_drop_cnt, n_drop_cnt;
    logic               mem_we, mem_re, ovf;

    logic               r_pv;
    logic               r_p_rd;
    logic               r_p_kind;
    logic [FILL_W-1:0]  r_p_fill;
    logic               r_p_primed;
    logic [CNT_W-1:0]   r_p_under;
    logic [CNT_W-1:0]   r_p_drop;
    logic               r_p_ovf;

    logic                          r_ov;
    logic signed [SAMPLE_BITS-1:0] r_o_sample;
    logic                          r_o_kind;
    logic [FILL_W-1:0]             r_o_fill;
    logic                          r_o_primed;
    logic [CNT_W-1:0]              r_o_under;
    logic [CNT_W-1:0]              r_o_drop;
    logic                          r_o_ovf;

    logic out_free, pend_move, pend_free, exec;

    assign out_free  = !r_ov || o_res.ready;
    assign pend_move = r_pv && out_free;
    assign pend_free = !r_pv || pend_move;
    assign exec      = i_q_valid && pend_free;
    assign o_q_pop   = exec;

    always_comb begin
        logic [FILL_W-1:0] drop_n;
        logic [FILL_W-1:0] fill_a;
        drop_n      = '0;
        fill_a      = r_fill;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_primed    = r_primed;
        n_silent    = r_silent;
        n_underran  = r_underran;
        n_under_cnt = r_under_cnt;
        n_drop_cnt  = r_drop_cnt;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        ovf         = 1'b0;
        case (i_q_item.op)
            OP_PUSH: begin
                if (i_q_item.first && (r_fill > FILL_W'(r_max))) begin
                    drop_n     = (FILL_W'(r_frame) < r_fill) ? FILL_W'(r_frame) : r_fill;
                    n_rp       = r_rp + drop_n[PTR_W-1:0];
                    fill_a     = r_fill - drop_n;
                    n_drop_cnt = r_drop_cnt + 1'b1;
                end
                n_fill = fill_a;
                if (fill_a >= FILL_W'(BUFFER_DEPTH)) begin
                    ovf = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    n_wp   = r_wp + 1'b1;
                    n_fill = fill_a + 1'b1;
                end
            end
            OP_PULL: begin
                if (i_q_item.first) begin
                    n_underran = 1'b0;
                    if (!r_primed) begin
                        if (r_fill >= FILL_W'(r_target)) begin
                            n_primed = 1'b1;
                            n_silent = 1'b0;
                        end else begin
                            n_silent = 1'b1;
                        end
                    end else begin
                        n_silent = 1'b0;
                    end
                end
                if (!n_silent && n_primed) begin
                    if (r_fill != '0) begin
                        mem_re = 1'b1;
                        n_rp   = r_rp + 1'b1;
                        n_fill = r_fill - 1'b1;
                    end else begin
                        if (!n_underran) begin
                            n_under_cnt = r_under_cnt + 1'b1;
                        end
                        n_underran = 1'b1;
                        n_primed   = 1'b0;
                        n_silent   = 1'b1;
                    end
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && exec) begin
            r_store[r_wp] <= i_q_item.sample;
        end
        if (mem_re && exec) begin
            r_rd_data <= r_store[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= FRAME_LENGTH_RST;
            r_target    <= TARGET_FILL_RST;
            r_max       <= MAX_FILL_RST;
            r_rp        <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_primed    <= 1'b0;
            r_silent    <= 1'b0;
            r_underran  <= 1'b0;
            r_under_cnt <= '0;
            r_drop_cnt  <= '0;
            r_pv        <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    REG_FRAME_LENGTH: r_frame  <= i_cfg.data[FRAME_W-1:0];
                    REG_TARGET_FILL:  r_target <= i_cfg.data[THR_W-1:0];
                    REG_MAX_FILL:     r_max    <= i_cfg.data[THR_W-1:0];
                    default: begin
                        r_frame <= r_frame;
                    end
                endcase
            end
            if (exec) begin
                r_rp        <= n_rp;
                r_wp        <= n_wp;
                r_fill      <= n_fill;
                r_primed    <= n_primed;
                r_silent    <= n_silent;
                r_underran  <= n_underran;
                r_under_cnt <= n_under_cnt;
                r_drop_cnt  <= n_drop_cnt;
            end
            if (exec) begin
                r_pv <= 1'b1;
            end else if (pend_move) begin
                r_pv <= 1'b0;
            end
            if (pend_move) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_p_rd     <= mem_re;
            r_p_kind   <= (i_q_item.op == OP_PULL);
            r_p_fill   <= n_fill;
            r_p_primed <= n_primed;
            r_p_under  <= n_under_cnt;
            r_p_drop   <= n_drop_cnt;
            r_p_ovf    <= ovf;
        end
        if (pend_move) begin
            r_o_sample <= r_p_rd ? r_rd_data : '0;
            r_o_kind   <= r_p_kind;
            r_o_fill   <= r_p_fill;
            r_o_primed <= r_p_primed;
            r_o_under  <= r_p_under;
            r_o_drop   <= r_p_drop;
            r_o_ovf    <= r_p_ovf;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.sample_out     = r_o_sample;
    assign o_res.out_valid      = r_o_kind;
    assign o_res.fill_level     = r_o_fill;
    assign o_res.is_primed      = r_o_primed;
    assign o_res.underrun_total = r_o_under;
    assign o_res.drop_total     = r_o_drop;
    assign o_res.overflow       = r_o_ovf;

endmodule

// ----- design/audio_jitter_buffer_gate_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Transfer when        Payload
// i_in      in         valid && ready       kind, sample_in, first
// o_res     out        valid && ready       sample_out, out_valid, fill_level, is_primed,
//                                           underrun_total, drop_total, overflow
// i_cfg_*   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item per cycle is sustained while o_res.ready is high; a result passes through the
// input queue and the execute step, whose registered memory read feeds the output
// register.
// Reset is synchronous and active low; the sample memory is not cleared.
// A two-entry queue separates intake from execution, and an output register lets
// the next item execute while a result waits, so each side stalls on its own.

module audio_jitter_buffer_gate_top import ajb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ajb_in_if.sink                i_in,
    ajb_out_if.source             o_res
);

    logic    q_valid;
    t_item   q_item;
    logic    q_pop;
    t_cfg_wr cfg;

    always_comb begin
        cfg.we   = i_cfg_we;
        cfg.idx  = i_cfg_idx;
        cfg.data = i_cfg_data;
    end

    ajb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    ajb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

// ----- design/ajb_checker.sv -----
`timescale 1ns / 1ps

module ajb_checker import ajb_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic signed [SAMPLE_BITS-1:0] i_sample_out,
    input logic                          i_out_valid,
    input logic [FILL_W-1:0]             i_fill_level,
    input logic                          i_overflow
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_sample_out) && $stable(i_fill_level)))
        else $error("Stalled result changed.");

    a_push_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_out_valid) |-> (i_sample_out == '0))
        else $error("Push result carries a sample.");

    a_ovf_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_overflow) |-> (!i_out_valid && (i_fill_level == FILL_W'(BUFFER_DEPTH))))
        else $error("Overflow flagged without a full buffer.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_fill_level <= FILL_W'(BUFFER_DEPTH)))
        else $error("Fill level exceeds the buffer depth.");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("Result valid after reset.");

endmodule

bind audio_jitter_buffer_gate_top ajb_checker u_ajb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_sample_out (o_res.sample_out),
    .i_out_valid  (o_res.out_valid),
    .i_fill_level (o_res.fill_level),
    .i_overflow   (o_res.overflow)
);
